/* rtl/core/fuzzy_membership_grade_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the fuzzy membership grade core
// Clocked on clock, disabled while reset is high; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef FUZZY_MEMBERSHIP_GRADE_CORE_ASSERT_SVH
`define FUZZY_MEMBERSHIP_GRADE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FMG_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("fmg check failed");
`define FMG_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fmg check failed");
`else
`define FMG_ASSERT(lbl, expr)
`define FMG_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* rtl/core/fmg_pkg.sv */
// ---------------------------------------------------------------------------
// fmg_pkg
// Shared constants and types of the fuzzy membership grade core.
// ---------------------------------------------------------------------------
package fmg_pkg;

   localparam int COORD_WIDTH_DEF     = 16;
   localparam int GRADE_FRAC_BITS_DEF = 15;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHAPE_MODE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEFT_EDGE  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEAK_START = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEAK_END   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_EDGE = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEAK_GAIN  = 3'd5;

   localparam logic MODE_TRIANGLE  = 1'b0;
   localparam logic MODE_TRAPEZOID = 1'b1;

   // per-item control that rides along the pipeline
   typedef struct packed {
      logic illegal;
      logic use_div;
   } fmg_ctrl_type;

endpackage

/* rtl/core/fuzzy_membership_grade_core.sv */
// Pipeline from start to rsp_valid: one classify stage, one multiply stage,
// one divider stage per grade bit and one output register. Throughput: one
// sample per cycle; busy is always low.
// Reset (synchronous, active high) empties the pipeline and loads the
// registers with trapezoid mode, zero corners and unity gain.
// ---------------------------------------------------------------------------
// fuzzy_membership_grade_core
// Triangular / trapezoidal membership grade, slopes as gain*dist/span.
// ---------------------------------------------------------------------------
`include "fuzzy_membership_grade_core_assert.svh"

module fuzzy_membership_grade_core
   import fmg_pkg::*;
#(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int GRADE_FRAC_BITS = GRADE_FRAC_BITS_DEF,
   localparam int QW   = GRADE_FRAC_BITS + 1,
   localparam int CSRW = (COORD_WIDTH > QW) ? COORD_WIDTH : QW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_sample_value,
   output logic                          rsp_valid,
   output logic [QW-1:0]                 rsp_grade,
   output logic                          rsp_shape_illegal,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSRW-1:0]               csr_write_data
);

   localparam int CW = COORD_WIDTH;
   localparam logic [QW-1:0] GRADE_ONE = {1'b1, {GRADE_FRAC_BITS{1'b0}}};

   // configuration registers
   logic                 shape_mode_ff;
   logic signed [CW-1:0] left_edge_ff, peak_start_ff, peak_end_ff, right_edge_ff;
   logic [QW-1:0]        peak_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_mode_ff <= MODE_TRAPEZOID;
         left_edge_ff  <= '0;
         peak_start_ff <= '0;
         peak_end_ff   <= '0;
         right_edge_ff <= '0;
         peak_gain_ff  <= GRADE_ONE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SHAPE_MODE: shape_mode_ff <= csr_write_data[0];
            CSR_LEFT_EDGE:  left_edge_ff  <= csr_write_data[CW-1:0];
            CSR_PEAK_START: peak_start_ff <= csr_write_data[CW-1:0];
            CSR_PEAK_END:   peak_end_ff   <= csr_write_data[CW-1:0];
            CSR_RIGHT_EDGE: right_edge_ff <= csr_write_data[CW-1:0];
            CSR_PEAK_GAIN:  peak_gain_ff  <= csr_write_data[QW-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // ---------------- stage 1: classify sample, pick span ----------------
   logic                 take;
   logic signed [CW:0]   d_vl, d_rv, d_ml, d_rm1, d_rm2;
   logic [QW-1:0]        gain_sat;
   logic                 illegal;
   logic                 rising, falling, on_peak;
   fmg_ctrl_type         s1_ctrl_in;
   logic [QW-1:0]        s1_fixed_in;
   logic [CW-1:0]        s1_num_in, s1_den_in;

   logic                 s1_valid_ff;
   fmg_ctrl_type         s1_ctrl_ff;
   logic [QW-1:0]        s1_fixed_ff, s1_gain_ff;
   logic [CW-1:0]        s1_num_ff, s1_den_ff;

   assign take = start & ~busy;

   always_comb begin
      d_vl  = {req_sample_value[CW-1], req_sample_value} - {left_edge_ff[CW-1], left_edge_ff};
      d_rv  = {right_edge_ff[CW-1], right_edge_ff} - {req_sample_value[CW-1], req_sample_value};
      d_ml  = {peak_start_ff[CW-1], peak_start_ff} - {left_edge_ff[CW-1], left_edge_ff};
      d_rm1 = {right_edge_ff[CW-1], right_edge_ff} - {peak_start_ff[CW-1], peak_start_ff};
      d_rm2 = {right_edge_ff[CW-1], right_edge_ff} - {peak_end_ff[CW-1], peak_end_ff};
      gain_sat = (peak_gain_ff > GRADE_ONE) ? GRADE_ONE : peak_gain_ff;

      if (shape_mode_ff == MODE_TRIANGLE) begin
         illegal = (left_edge_ff > peak_start_ff) || (left_edge_ff > right_edge_ff)
                   || (peak_start_ff > right_edge_ff);
         rising  = (req_sample_value < peak_start_ff) && (req_sample_value > left_edge_ff);
         falling = (req_sample_value > peak_start_ff) && (req_sample_value < right_edge_ff);
         on_peak = (req_sample_value == peak_start_ff);
      end else begin
         illegal = (left_edge_ff > peak_start_ff) || (peak_start_ff > peak_end_ff)
                   || (peak_end_ff > right_edge_ff);
         rising  = (req_sample_value >= left_edge_ff) && (req_sample_value < peak_start_ff);
         on_peak = (req_sample_value >= peak_start_ff) && (req_sample_value < peak_end_ff);
         falling = (req_sample_value >= peak_end_ff) && (req_sample_value < right_edge_ff);
      end

      s1_ctrl_in.illegal = illegal;
      s1_ctrl_in.use_div = ~illegal & (rising | falling);
      s1_fixed_in = (~illegal & on_peak) ? gain_sat : '0;

      if (rising) begin
         s1_num_in = d_vl[CW-1:0];
         s1_den_in = d_ml[CW-1:0];
      end else begin
         s1_num_in = d_rv[CW-1:0];
         s1_den_in = (shape_mode_ff == MODE_TRIANGLE) ? d_rm1[CW-1:0] : d_rm2[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take;
      end
      s1_ctrl_ff  <= s1_ctrl_in;
      s1_fixed_ff <= s1_fixed_in;
      s1_gain_ff  <= gain_sat;
      s1_num_ff   <= s1_num_in;
      s1_den_ff   <= s1_den_in;
   end

   // ---------------- stage 2: gain * distance ----------------
   logic                 s2_valid_ff;
   fmg_ctrl_type         s2_ctrl_ff;
   logic [QW-1:0]        s2_fixed_ff;
   logic [QW+CW-1:0]     s2_prod_ff, s2_prod_in;
   logic [CW-1:0]        s2_den_ff;

   assign s2_prod_in = {{CW{1'b0}}, s1_gain_ff} * {{QW{1'b0}}, s1_num_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ctrl_ff  <= s1_ctrl_ff;
      s2_fixed_ff <= s1_fixed_ff;
      s2_prod_ff  <= s2_prod_in;
      s2_den_ff   <= s1_den_ff;
   end

   // ---------------- divider: product / span ----------------
   logic                 dv_valid;
   logic [QW-1:0]        dv_quot, dv_fixed;
   fmg_ctrl_type         dv_ctrl;

   fmg_divider #(
      .DEN_WIDTH  (CW),
      .QUOT_WIDTH (QW)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid_ff),
      .in_dividend (s2_prod_ff),
      .in_den      (s2_den_ff),
      .in_ctrl     (s2_ctrl_ff),
      .in_fixed    (s2_fixed_ff),
      .out_valid   (dv_valid),
      .out_quot    (dv_quot),
      .out_ctrl    (dv_ctrl),
      .out_fixed   (dv_fixed)
   );

   // ---------------- output register ----------------
   logic                 rsp_valid_ff;
   logic [QW-1:0]        rsp_grade_ff, rsp_grade_in;
   logic                 rsp_illegal_ff;

   assign rsp_grade_in = dv_ctrl.use_div ? dv_quot : dv_fixed;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
      rsp_grade_ff   <= rsp_grade_in;
      rsp_illegal_ff <= dv_ctrl.illegal;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_grade         = rsp_grade_ff;
   assign rsp_shape_illegal = rsp_illegal_ff;

   // ---------------- checks ----------------
   `FMG_ASSERT_IMP(a_illegal_zero, rsp_valid && rsp_shape_illegal, rsp_grade == '0)
   `FMG_ASSERT_IMP(a_grade_le_one, rsp_valid, rsp_grade <= GRADE_ONE)
   `FMG_ASSERT_IMP(a_span_nonzero, s1_valid_ff && s1_ctrl_ff.use_div, s1_den_ff != '0)

endmodule

/* rtl/core/fmg_divider.sv */
// ---------------------------------------------------------------------------
// fmg_divider
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits in QUOT_WIDTH bits (dividend < den << QUOT_WIDTH).
// ---------------------------------------------------------------------------
module fmg_divider
   import fmg_pkg::*;
#(
   parameter int DEN_WIDTH  = COORD_WIDTH_DEF,
   parameter int QUOT_WIDTH = GRADE_FRAC_BITS_DEF + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [QUOT_WIDTH+DEN_WIDTH-1:0] in_dividend,
   input  logic [DEN_WIDTH-1:0]            in_den,
   input  fmg_ctrl_type                    in_ctrl,
   input  logic [QUOT_WIDTH-1:0]           in_fixed,
   output logic                            out_valid,
   output logic [QUOT_WIDTH-1:0]           out_quot,
   output fmg_ctrl_type                    out_ctrl,
   output logic [QUOT_WIDTH-1:0]           out_fixed
);

   localparam int PW = QUOT_WIDTH + DEN_WIDTH;
   localparam int QW = QUOT_WIDTH;
   localparam int DW = DEN_WIDTH;

   // index 0 is the stage input, index k+1 the register after step k
   logic              st_valid [QW+1];
   logic [PW-1:0]     st_dvd   [QW+1];
   logic [DW-1:0]     st_rem   [QW+1];
   logic [DW-1:0]     st_den   [QW+1];
   logic [QW-1:0]     st_quo   [QW+1];
   fmg_ctrl_type      st_ctrl  [QW+1];
   logic [QW-1:0]     st_fixed [QW+1];

   assign st_valid[0] = in_valid;
   assign st_dvd[0]   = in_dividend;
   assign st_rem[0]   = in_dividend[PW-1 -: DW];
   assign st_den[0]   = in_den;
   assign st_quo[0]   = '0;
   assign st_ctrl[0]  = in_ctrl;
   assign st_fixed[0] = in_fixed;

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int BIT = QW - 1 - k;

      logic              valid_ff;
      logic [PW-1:0]     dvd_ff;
      logic [DW-1:0]     rem_ff, rem_in;
      logic [DW-1:0]     den_ff;
      logic [QW-1:0]     quo_ff, quo_in;
      fmg_ctrl_type      ctrl_ff;
      logic [QW-1:0]     fixed_ff;
      logic [DW:0]       trial;
      logic [DW+1:0]     diff;
      logic              fits;

      always_comb begin
         trial  = {st_rem[k], st_dvd[k][BIT]};
         diff   = {1'b0, trial} - {2'b00, st_den[k]};
         fits   = ~diff[DW+1];
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {st_quo[k][QW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= st_valid[k];
         end
         dvd_ff   <= st_dvd[k];
         rem_ff   <= rem_in;
         den_ff   <= st_den[k];
         quo_ff   <= quo_in;
         ctrl_ff  <= st_ctrl[k];
         fixed_ff <= st_fixed[k];
      end

      assign st_valid[k+1] = valid_ff;
      assign st_dvd[k+1]   = dvd_ff;
      assign st_rem[k+1]   = rem_ff;
      assign st_den[k+1]   = den_ff;
      assign st_quo[k+1]   = quo_ff;
      assign st_ctrl[k+1]  = ctrl_ff;
      assign st_fixed[k+1] = fixed_ff;
   end

   assign out_valid = st_valid[QW];
   assign out_quot  = st_quo[QW];
   assign out_ctrl  = st_ctrl[QW];
   assign out_fixed = st_fixed[QW];

endmodule
